[rtl/cau_pkg.sv]
// Shared types, codes, constants and helpers for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MOD = 3'd4
  } cau_act_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUO_BITS      = 33;
  localparam int CORE_LAT      = 34;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } cau_fin_t;

  typedef struct packed {
    logic [2:0]  act;
    logic        dz;
    logic [31:0] fast_re;
    logic [31:0] fast_im;
    logic        fast_sat;
    logic [63:0] num_re;
    logic [63:0] num_im;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] den;
  } cau_front_t;

  typedef struct packed {
    logic [2:0]  act;
    logic        dz;
    logic [31:0] fast_re;
    logic [31:0] fast_im;
    logic        fast_sat;
    logic        neg_re;
    logic        neg_im;
  } cau_side_t;

  // Applies a sign to a magnitude and clamps the result to 32 bits.
  function automatic cau_fin_t fin(input logic [63:0] mag, input logic neg);
    cau_fin_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.val = Q_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = 32'(~mag[31:0] + 32'd1);
      end
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        r.val = Q_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  // Clamps a 33-bit signed sum to 32 bits.
  function automatic cau_fin_t sat33(input logic [32:0] s);
    cau_fin_t r;
    r.sat = s[32] != s[31];
    if (r.sat) begin
      r.val = s[32] ? Q_MIN : Q_MAX;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/cau_if.sv]
// Valid/ready channel interfaces for operand and result beats.
`default_nettype none

interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

`default_nettype wire

[rtl/cau_front.sv]
// Front end: products, sums and magnitudes, and the add, subtract and multiply results.
`default_nettype none

module cau_front
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         action,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output cau_front_t         fo
);

  logic [2:0]         s1_act;
  logic               s1_dz;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic signed [32:0] s1_as_re, s1_as_im;

  logic [2:0]         s2_act;
  logic               s2_dz;
  logic [63:0]        s2_mre, s2_mim, s2_den;
  logic               s2_nre, s2_nim;
  logic signed [32:0] s2_as_re, s2_as_im;

  logic signed [64:0] sum_re, sum_im, abs_re, abs_im;
  logic [63:0]        nar_re, nar_im;
  cau_fin_t           f_re, f_im;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act <= action;
      s1_dz  <= (b_re == 32'sd0) && (b_im == 32'sd0);
      p_rr   <= a_re * b_re;
      p_ii   <= a_im * b_im;
      p_ri   <= a_re * b_im;
      p_ir   <= a_im * b_re;
      p_br   <= b_re * b_re;
      p_bi   <= b_im * b_im;
      if (action == ACT_SUB) begin
        s1_as_re <= 33'(a_re) - 33'(b_re);
        s1_as_im <= 33'(a_im) - 33'(b_im);
      end else begin
        s1_as_re <= 33'(a_re) + 33'(b_re);
        s1_as_im <= 33'(a_im) + 33'(b_im);
      end
    end
  end

  always_comb begin
    if (s1_act == ACT_MUL) begin
      sum_re = 65'(p_rr) - 65'(p_ii);
      sum_im = 65'(p_ri) + 65'(p_ir);
    end else begin
      sum_re = 65'(p_rr) + 65'(p_ii);
      sum_im = 65'(p_ir) - 65'(p_ri);
    end
    abs_re = sum_re[64] ? -sum_re : sum_re;
    abs_im = sum_im[64] ? -sum_im : sum_im;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_act   <= s1_act;
      s2_dz    <= s1_dz;
      s2_nre   <= sum_re[64];
      s2_nim   <= sum_im[64];
      s2_mre   <= abs_re[63:0];
      s2_mim   <= abs_im[63:0];
      s2_den   <= $unsigned(p_br) + $unsigned(p_bi);
      s2_as_re <= s1_as_re;
      s2_as_im <= s1_as_im;
    end
  end

  always_comb begin
    nar_re = (s2_mre >> FRAC_BITS) + {63'd0, s2_mre[FRAC_BITS-1]};
    nar_im = (s2_mim >> FRAC_BITS) + {63'd0, s2_mim[FRAC_BITS-1]};
    case (s2_act)
      ACT_ADD, ACT_SUB: begin
        f_re = sat33(s2_as_re);
        f_im = sat33(s2_as_im);
      end
      ACT_MUL: begin
        f_re = fin(nar_re, s2_nre);
        f_im = fin(nar_im, s2_nim);
      end
      default: begin
        f_re = '0;
        f_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo.act      <= s2_act;
      fo.dz       <= s2_dz;
      fo.fast_re  <= f_re.val;
      fo.fast_im  <= f_im.val;
      fo.fast_sat <= f_re.sat | f_im.sat;
      fo.num_re   <= s2_mre;
      fo.num_im   <= s2_mim;
      fo.neg_re   <= s2_nre;
      fo.neg_im   <= s2_nim;
      fo.den      <= s2_den;
    end
  end

endmodule

`default_nettype wire

[rtl/cau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, rounded and capped.
`default_nettype none

module cau_div
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [33:0] quo
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int HW = NW - QUO_BITS;

  logic [NW-1:0]       nfull;
  logic [63:0]         hi;
  logic [63:0]         rem  [0:QUO_BITS];
  logic [QUO_BITS-1:0] lo   [0:QUO_BITS];
  logic [63:0]         dv   [0:QUO_BITS];
  logic [QUO_BITS-1:0] q    [0:QUO_BITS];
  logic                ovf  [0:QUO_BITS];
  logic                rnd;

  assign nfull = {num, {FRAC_BITS{1'b0}}};
  assign hi    = {{(64-HW){1'b0}}, nfull[NW-1:QUO_BITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi;
      lo[0]  <= nfull[QUO_BITS-1:0];
      dv[0]  <= den;
      q[0]   <= '0;
      ovf[0] <= hi >= den;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [64:0] t, diff;
    logic        ge;
    assign t    = {rem[k], lo[k][QUO_BITS-1]};
    assign diff = t - {1'b0, dv[k]};
    assign ge   = t >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[63:0] : t[63:0];
        lo[k+1]  <= {lo[k][QUO_BITS-2:0], 1'b0};
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][QUO_BITS-2:0], ge};
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign rnd = {rem[QUO_BITS], 1'b0} >= {1'b0, dv[QUO_BITS]};
  assign quo = ovf[QUO_BITS] ? 34'h1_0000_0000
                             : {1'b0, q[QUO_BITS]} + {33'd0, rnd};

endmodule

`default_nettype wire

[rtl/cau_sqrt.sv]
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
`default_nettype none

module cau_sqrt
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [33:0] root
);

  localparam int STEPS = CORE_LAT - 2;

  logic [63:0] vv [0:STEPS];
  logic [63:0] rr [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      vv[0] <= rad;
      rr[0] <= '0;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [63:0] one, trial;
    logic        ge;
    assign one   = 64'd1 << (62 - 2 * j);
    assign trial = rr[j] + one;
    assign ge    = vv[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        vv[j+1] <= ge ? vv[j] - trial : vv[j];
        rr[j+1] <= ge ? (rr[j] >> 1) + one : rr[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= rr[STEPS][33:0] + {33'd0, vv[STEPS] > rr[STEPS]};
    end
  end

endmodule

`default_nettype wire

[rtl/complex_arith_unit.sv]
// Top level of the complex arithmetic unit: pipeline control, alignment and result select.
//
//   channel | dir | beat contents
//   op      | in  | action, a_re, a_im, b_re, b_im
//   res     | out | res_re, res_im, status
//
// The pipeline depth is set by the divider, one quotient bit per stage, with the square
// root running alongside it. A new beat can enter every cycle unless a held result
// beat stalls the pipeline.
// Reset clears only the valid bits of the pipeline.
// When a result beat is held, the whole pipeline holds and op.ready falls.
`default_nettype none

module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cau_in_if.sink    op,
  cau_out_if.source res
);

  localparam int TOTAL = 4 + CORE_LAT + 1;

  logic               en;
  logic [TOTAL-1:0]   vld;
  logic [2:0]         i_act;
  logic signed [31:0] i_are, i_aim, i_bre, i_bim;
  cau_front_t         fo;
  cau_side_t          side [0:CORE_LAT-1];
  cau_side_t          sl;
  logic [33:0]        q_re, q_im, root;
  cau_fin_t           d_re, d_im, m_re;
  logic [31:0]        o_re, o_im;
  logic [1:0]         o_st;
  logic               o_sat;

  assign en       = !vld[TOTAL-1] || res.ready;
  assign op.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], op.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_act <= op.action;
      i_are <= op.a_re;
      i_aim <= op.a_im;
      i_bre <= op.b_re;
      i_bim <= op.b_im;
    end
  end

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(en), .action(i_act),
    .a_re(i_are), .a_im(i_aim), .b_re(i_bre), .b_im(i_bim), .fo(fo)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk(clk), .en(en), .num(fo.num_re), .den(fo.den), .quo(q_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk(clk), .en(en), .num(fo.num_im), .den(fo.den), .quo(q_im)
  );

  cau_sqrt u_sqrt (
    .clk(clk), .en(en), .rad(fo.den), .root(root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].act      <= fo.act;
      side[0].dz       <= fo.dz;
      side[0].fast_re  <= fo.fast_re;
      side[0].fast_im  <= fo.fast_im;
      side[0].fast_sat <= fo.fast_sat;
      side[0].neg_re   <= fo.neg_re;
      side[0].neg_im   <= fo.neg_im;
      for (int i = 1; i < CORE_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign sl   = side[CORE_LAT-1];
  assign d_re = fin({30'd0, q_re}, sl.neg_re);
  assign d_im = fin({30'd0, q_im}, sl.neg_im);
  assign m_re = fin({30'd0, root}, 1'b0);

  always_comb begin
    o_re  = '0;
    o_im  = '0;
    o_sat = 1'b0;
    o_st  = ST_OK;
    unique case (cau_act_t'(sl.act))
      ACT_ADD, ACT_SUB, ACT_MUL: begin
        o_re  = sl.fast_re;
        o_im  = sl.fast_im;
        o_sat = sl.fast_sat;
      end
      ACT_DIV: begin
        if (!sl.dz) begin
          o_re  = d_re.val;
          o_im  = d_im.val;
          o_sat = d_re.sat | d_im.sat;
        end
      end
      ACT_MOD: begin
        o_re  = m_re.val;
        o_sat = m_re.sat;
      end
      default: begin
        o_re = '0;
      end
    endcase
    if (sl.act == ACT_DIV && sl.dz) begin
      o_st = ST_DZ;
    end else if (o_sat) begin
      o_st = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.res_re <= o_re;
      res.res_im <= o_im;
      res.status <= o_st;
    end
  end

  assign res.valid = vld[TOTAL-1];

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_DZ |-> res.res_re == 32'sd0 && res.res_im == 32'sd0)
    else $error("divide by zero beat carries a nonzero result");

  a_sat_edge: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_SAT |->
      res.res_re == Q_MAX || res.res_re == Q_MIN ||
      res.res_im == Q_MAX || res.res_im == Q_MIN)
    else $error("saturated beat has no clamped part");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.status != 2'd3)
    else $error("undefined status code");

  a_hold_ready: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !op.ready)
    else $error("pipeline advanced while result beat was held");

endmodule

`default_nettype wire

[tb/cau_checker.sv]
// Checker that predicts complex ALU results from operand beats and compares result beats.
module cau_checker
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cau_in_if.sink    op,
  cau_out_if.sink   res,
  output int        errors,
  output int        pending
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cau_res_t;

  localparam int FB = FRAC_BITS_DEF;

  cau_res_t want_q[$];

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] clampv(input logic [63:0] mag, input logic neg,
                                         inout logic sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        return 64'hffff_ffff_8000_0000;
      end
      return 64'(-mag);
    end
    if (mag > 64'h7fff_ffff) begin
      sat = 1'b1;
      return 64'h7fff_ffff;
    end
    return mag;
  endfunction

  function automatic logic [63:0] round_q(input logic [127:0] mag);
    return 64'((mag >> FB) + ((mag >> (FB - 1)) & 1));
  endfunction

  function automatic logic [63:0] quot(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] q, r;
    q = (num << FB) / den;
    r = (num << FB) % den;
    if (r >= den - r) q = q + 1;
    if (q > (128'd1 << 32)) q = 128'd1 << 32;
    return q[63:0];
  endfunction

  function automatic logic [63:0] isqrt_round(input logic [127:0] v);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'd1 << 32;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    if (v - lo * lo > lo) lo = lo + 1;
    return lo[63:0];
  endfunction

  function automatic cau_res_t compute(input logic [2:0] act,
                                       input logic signed [31:0] ar, ai, br, bi);
    cau_res_t r;
    logic sat;
    logic signed [127:0] sr, si;
    logic [127:0] m;
    sat = 1'b0;
    r.re = '0;
    r.im = '0;
    r.st = ST_OK;
    case (act)
      ACT_ADD, ACT_SUB: begin
        sr = act == ACT_ADD ? 128'(ar) + 128'(br) : 128'(ar) - 128'(br);
        si = act == ACT_ADD ? 128'(ai) + 128'(bi) : 128'(ai) - 128'(bi);
        r.re = 32'(clampv(absv(64'(sr)), sr < 0, sat));
        r.im = 32'(clampv(absv(64'(si)), si < 0, sat));
      end
      ACT_MUL: begin
        sr = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi);
        si = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br);
        r.re = 32'(clampv(round_q(sr < 0 ? -sr : sr), sr < 0, sat));
        r.im = 32'(clampv(round_q(si < 0 ? -si : si), si < 0, sat));
      end
      ACT_DIV: begin
        if (br == 0 && bi == 0) begin
          r.st = ST_DZ;
        end else begin
          m = 128'(128'(br) * 128'(br) + 128'(bi) * 128'(bi));
          sr = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
          si = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
          r.re = 32'(clampv(quot(sr < 0 ? -sr : sr, m), sr < 0, sat));
          r.im = 32'(clampv(quot(si < 0 ? -si : si, m), si < 0, sat));
        end
      end
      ACT_MOD: begin
        m = 128'(128'(br) * 128'(br) + 128'(bi) * 128'(bi));
        r.re = 32'(clampv(isqrt_round(m), 1'b0, sat));
      end
      default: ;
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  always @(posedge clk) begin
    cau_res_t w;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (op.valid && op.ready) begin
        want_q.push_back(compute(op.action, op.a_re, op.a_im, op.b_re, op.b_im));
      end
      if (res.valid && res.ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result beat re=%h im=%h st=%0d", $realtime,
                   res.res_re, res.res_im, res.status);
          errors <= errors + 1;
        end else begin
          w = want_q.pop_front();
          if (w.re !== res.res_re || w.im !== res.res_im || w.st !== res.status) begin
            $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                     $realtime, w.re, w.im, w.st, res.res_re, res.res_im, res.status);
            errors <= errors + 1;
          end
        end
      end
      pending <= want_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top: drives operand beats with random gaps and stalls and gives the verdict.
module tb_top;
  import cau_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  cau_in_if  op_ch ();
  cau_out_if res_ch ();

  complex_arith_unit dut (.clk(clk), .rst(rst), .op(op_ch.sink), .res(res_ch.source));
  cau_checker chk (.clk(clk), .rst(rst), .op(op_ch.sink), .res(res_ch.sink),
                   .errors(errors), .pending(pending));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** complex_arith_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [31:0] pick_val();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
      4: return $urandom & 32'h000f_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [2:0] act, input logic [31:0] ar, ai, br, bi);
    while ($urandom_range(99) < idle_pct) begin
      op_ch.valid <= 1'b0;
      @(negedge clk);
    end
    op_ch.valid  <= 1'b1;
    op_ch.action <= act;
    op_ch.a_re   <= ar;
    op_ch.a_im   <= ai;
    op_ch.b_re   <= br;
    op_ch.b_im   <= bi;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_burst(input int n, input int ip, input int sp);
    logic [2:0] act;
    idle_pct  = ip;
    stall_pct = sp;
    repeat (n) begin
      act = $urandom_range(9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      if ($urandom_range(15) == 0)
        send(act, pick_val(), pick_val(), 32'h0, 32'h0);
      else
        send(act, pick_val(), pick_val(), pick_val(), pick_val());
    end
  endtask

  initial begin
    op_ch.valid  = 1'b0;
    op_ch.action = ACT_ADD;
    op_ch.a_re   = '0;
    op_ch.a_im   = '0;
    op_ch.b_re   = '0;
    op_ch.b_im   = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send(ACT_ADD, Q_MAX, Q_MIN, 32'd1, 32'hffff_ffff);
    send(ACT_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send(ACT_SUB, Q_MIN, Q_MAX, 32'd1, 32'hffff_ffff);
    send(ACT_SUB, 32'h0001_0000, 32'h0, 32'h0002_8000, 32'h0);
    send(ACT_MUL, 32'h0001_8000, 32'h0002_0000, 32'hffff_0000, 32'h0000_8000);
    send(ACT_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send(ACT_MUL, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    send(ACT_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
    send(ACT_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send(ACT_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send(ACT_DIV, Q_MAX, Q_MAX, 32'h0000_0001, 32'h0);
    send(ACT_DIV, Q_MIN, Q_MIN, 32'h0, 32'h0000_0001);
    send(ACT_DIV, 32'h1, 32'h0, Q_MIN, Q_MIN);
    send(ACT_MOD, 32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000);
    send(ACT_MOD, 32'h0, 32'h0, Q_MIN, Q_MIN);
    send(ACT_MOD, 32'h0, 32'h0, 32'h0, 32'h0);
    send(ACT_MOD, 32'h0, 32'h0, Q_MAX, 32'h0);
    send(3'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send(3'd7, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    random_burst(250, 0, 0);
    random_burst(200, 85, 0);
    random_burst(200, 0, 85);
    random_burst(250, 37, 37);
    op_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** complex_arith_unit: PASSED **");
    end else begin
      $display("** complex_arith_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_div.sv
rtl/cau_sqrt.sv
rtl/complex_arith_unit.sv
tb/cau_checker.sv
tb/tb_top.sv
